// ----- sv/hrhp_pkg.sv -----
// Package with the types, codes and constants of the HTTP response header parser.
package hrhp_pkg;

  localparam int LENGTH_BITS = 40;
  localparam int CONTENT_BITS = 40;
  localparam int STATUS_BITS = 16;
  localparam int POS_BITS = 5;

  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [7:0] BYTE_LF = 8'd10;
  localparam logic [7:0] BYTE_CR = 8'd13;

  localparam int STATUS_TEXT_LEN = 9;
  localparam int LENGTH_TEXT_LEN = 15;

  // Status line prefix; the minor version digit may also be a one.
  localparam logic [0:STATUS_TEXT_LEN-1][7:0] STATUS_TEXT = {
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30, 8'h20
  };

  // Lower case header name including the colon.
  localparam logic [0:LENGTH_TEXT_LEN-1][7:0] LENGTH_TEXT = {
    8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
  };

  typedef enum logic [1:0] {
    MODE_PREFIX = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_IGNORE = 2'd2
  } line_mode_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_PROTOCOL  = 3'd1,
    ERR_STATUS    = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_DUPLICATE = 3'd4
  } error_t;

  typedef struct packed {
    logic [POS_BITS-1:0]    line_position;
    line_mode_t             line_mode;
    logic [LENGTH_BITS-1:0] number_accumulator;
    logic                   digits_seen;
    logic [STATUS_BITS-1:0] status_register;
    logic [LENGTH_BITS-1:0] length_register;
    logic                   length_valid;
    error_t                 error_register;
    logic                   done_flag;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    line_position:      '0,
    line_mode:          MODE_PREFIX,
    number_accumulator: '0,
    digits_seen:        1'b0,
    status_register:    '0,
    length_register:    '0,
    length_valid:       1'b0,
    error_register:     ERR_NONE,
    done_flag:          1'b0
  };

endpackage

// ----- sv/hrhp_in_if.sv -----
// Request channel interface carrying one byte of the response stream.
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

// ----- sv/hrhp_out_if.sv -----
// Result channel interface carrying the parser status after each byte.
interface hrhp_out_if;
  logic                              valid;
  logic                              ready;
  logic                              headers_done;
  logic [hrhp_pkg::STATUS_BITS-1:0]  status_code;
  logic [hrhp_pkg::CONTENT_BITS-1:0] content_length;
  logic                              length_known;
  logic [2:0]                        error_code;

  modport source (output valid, output headers_done, output status_code,
                  output content_length, output length_known, output error_code,
                  input ready);
  modport sink (input valid, input headers_done, input status_code,
                input content_length, input length_known, input error_code,
                output ready);
endinterface

// ----- sv/http_response_header_parser.sv -----
// Top level of the HTTP/1.x response header parser, one byte per request.
//
// The parser takes a response stream one byte per request and after every byte
// returns one result with the header status seen so far: headers_done, the final
// status code, the content length with its known flag, and a sticky error code.
// A request with first_byte set clears all parser state before its byte is used,
// starting a new response. Lines end at LF and a CR directly before the LF is
// dropped; an empty line ends the header block. The first line must start with
// "HTTP/1.0 " or "HTTP/1.1 " followed by a nonzero decimal status, and 1xx
// statuses are skipped. A "content-length:" line (any case) gives the length;
// numbers saturate. After an error or the end of the headers, bytes are ignored
// until the next first_byte. Timing: an accepted request is held in an input
// register and parsed into the state registers once the result slot is free;
// the state registers are also the result payload, and one request is taken
// every clock as long as results are taken. The rate is set by the state
// update loop: each byte's parse depends on the state left by the previous
// byte, and that update is done by combinational logic into those registers.
module http_response_header_parser (
  input  logic              clk,
  input  logic              rst,
  hrhp_in_if.sink           req,
  hrhp_out_if.source        rsp
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;

  // Parser state; it also serves as the result register.
  hrhp_pkg::parse_state_t state;
  hrhp_pkg::parse_state_t state_next;
  logic                   last_was_cr;
  logic                   last_was_cr_next;
  logic                   out_valid;

  logic advance;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C ||
           c == hrhp_pkg::BYTE_CR || c == hrhp_pkg::BYTE_LF;
  endfunction

  // Closes a number field: the status while no final status is known, else a length.
  function automatic hrhp_pkg::parse_state_t finish_number(
    input hrhp_pkg::parse_state_t s,
    input logic                   ended_well
  );
    hrhp_pkg::parse_state_t n;
    logic [hrhp_pkg::LENGTH_BITS-1:0] v;
    n = s;
    v = s.number_accumulator;
    n.line_mode = hrhp_pkg::MODE_IGNORE;
    if (s.status_register == '0) begin
      if (!ended_well || v == '0) begin
        n.error_register = hrhp_pkg::ERR_STATUS;
      end else if (!(v >= hrhp_pkg::LENGTH_BITS'(100) && v < hrhp_pkg::LENGTH_BITS'(200))) begin
        if (v > hrhp_pkg::LENGTH_BITS'(16'hFFFF)) begin
          n.status_register = '1;
        end else begin
          n.status_register = v[hrhp_pkg::STATUS_BITS-1:0];
        end
      end
    end else begin
      if (!ended_well) begin
        n.error_register = hrhp_pkg::ERR_LENGTH;
      end else if (s.length_valid && v != s.length_register) begin
        n.error_register = hrhp_pkg::ERR_DUPLICATE;
      end else begin
        n.length_register = v;
        n.length_valid = 1'b1;
      end
    end
    return n;
  endfunction

  // Parses one ordinary (non-LF) byte.
  function automatic hrhp_pkg::parse_state_t take_char(
    input hrhp_pkg::parse_state_t s,
    input logic [7:0]             c
  );
    hrhp_pkg::parse_state_t n;
    logic [7:0] lc;
    logic [hrhp_pkg::LENGTH_BITS+3:0] wide;
    logic [3:0] idx;
    n = s;
    idx = s.line_position[3:0];
    lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    wide = ({4'b0, s.number_accumulator} << 3) + ({4'b0, s.number_accumulator} << 1) +
           (hrhp_pkg::LENGTH_BITS+4)'(c[3:0]);
    if (s.error_register != hrhp_pkg::ERR_NONE || s.done_flag) begin
      return n;
    end
    if (s.line_mode == hrhp_pkg::MODE_PREFIX) begin
      if (s.status_register == '0) begin
        if (s.line_position > 5'd8) begin
          n.line_mode = hrhp_pkg::MODE_IGNORE;
        end else if (c == hrhp_pkg::STATUS_TEXT[idx] ||
                     (s.line_position == 5'd7 && c == 8'h31)) begin
          if (s.line_position == 5'd8) begin
            n.line_mode = hrhp_pkg::MODE_NUMBER;
          end
        end else begin
          // A broken status line stops here without counting the byte.
          n.error_register = hrhp_pkg::ERR_PROTOCOL;
          return n;
        end
      end else begin
        if (s.line_position > 5'd14 || lc != hrhp_pkg::LENGTH_TEXT[idx]) begin
          n.line_mode = hrhp_pkg::MODE_IGNORE;
        end else if (s.line_position == 5'd14) begin
          n.line_mode = hrhp_pkg::MODE_NUMBER;
        end
      end
    end else if (s.line_mode == hrhp_pkg::MODE_NUMBER) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        // Saturating multiply by ten plus the digit.
        if (wide > {4'b0, hrhp_pkg::LENGTH_MAX}) begin
          n.number_accumulator = hrhp_pkg::LENGTH_MAX;
        end else begin
          n.number_accumulator = wide[hrhp_pkg::LENGTH_BITS-1:0];
        end
        n.digits_seen = 1'b1;
      end else if (!(!s.digits_seen && is_space(c))) begin
        n = finish_number(n, is_space(c));
      end
    end
    if (s.line_position < hrhp_pkg::POS_MAX) begin
      n.line_position = s.line_position + 5'd1;
    end
    return n;
  endfunction

  // Handles a line feed: an empty line ends the headers.
  function automatic hrhp_pkg::parse_state_t end_line(input hrhp_pkg::parse_state_t s);
    hrhp_pkg::parse_state_t n;
    n = s;
    if (s.line_position == '0) begin
      n.done_flag = 1'b1;
    end else if (s.line_mode == hrhp_pkg::MODE_PREFIX && s.status_register == '0) begin
      n.error_register = hrhp_pkg::ERR_PROTOCOL;
    end else if (s.line_mode == hrhp_pkg::MODE_NUMBER) begin
      n = finish_number(s, 1'b1);
    end
    n.line_position = '0;
    n.line_mode = hrhp_pkg::MODE_PREFIX;
    n.number_accumulator = '0;
    n.digits_seen = 1'b0;
    return n;
  endfunction

  // The parse stage advances when a byte is held and the result slot is free.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      in_byte  <= req.data_byte;
      in_first <= req.first_byte;
    end
  end

  // Next state for the held byte. A CR is kept back one byte: if an LF follows it
  // is dropped, otherwise it is parsed as an ordinary byte ahead of the new one.
  always_comb begin
    hrhp_pkg::parse_state_t s;
    logic cr;
    s  = in_first ? hrhp_pkg::STATE_RESET : state;
    cr = in_first ? 1'b0 : last_was_cr;
    if (s.error_register == hrhp_pkg::ERR_NONE && !s.done_flag) begin
      if (in_byte == hrhp_pkg::BYTE_LF) begin
        cr = 1'b0;
        s  = end_line(s);
      end else begin
        if (cr) begin
          cr = 1'b0;
          s  = take_char(s, hrhp_pkg::BYTE_CR);
        end
        if (s.error_register == hrhp_pkg::ERR_NONE) begin
          if (in_byte == hrhp_pkg::BYTE_CR) begin
            cr = 1'b1;
          end else begin
            s = take_char(s, in_byte);
          end
        end
      end
    end
    state_next       = s;
    last_was_cr_next = cr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hrhp_pkg::STATE_RESET;
      last_was_cr <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        state       <= state_next;
        last_was_cr <= last_was_cr_next;
        out_valid   <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The state only changes when a new result is loaded, so it drives the payload.
  assign rsp.valid          = out_valid;
  assign rsp.headers_done   = state.done_flag;
  assign rsp.status_code    = state.status_register;
  assign rsp.content_length = hrhp_pkg::CONTENT_BITS'(state.length_register);
  assign rsp.length_known   = state.length_valid;
  assign rsp.error_code     = state.error_register;

endmodule
